FILE: rtl/dsfr_pkg.sv
`default_nettype none
package dsfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 9;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int MAX_FRAME_DEFAULT = 256;
  localparam int FIFO_DEPTH = 4;

  localparam logic [BYTE_W-1:0] SYN_CHAR = 8'h16;
  localparam logic [BYTE_W-1:0] DLE_CHAR = 8'h10;
  localparam logic [BYTE_W-1:0] STX_CHAR = 8'h02;
  localparam logic [BYTE_W-1:0] ETX_CHAR = 8'h03;

  localparam logic REG_RX_ENABLE = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNS,
    PH_STX,
    PH_DATA,
    PH_ESC
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [LEN_W-1:0]  frame_length;
    logic              empty_frame;
  } result_t;

  typedef struct packed {
    logic             rx_enable;
    logic [LEN_W-1:0] max_frame_length;
    logic             drop;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/dsfr_if.sv
`default_nettype none
interface dsfr_byte_if;
  logic                          valid;
  logic                          ready;
  logic [dsfr_pkg::BYTE_W-1:0]   rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface dsfr_result_if;
  logic                          valid;
  logic                          ready;
  logic [dsfr_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;
  logic [dsfr_pkg::LEN_W-1:0]    frame_length;
  logic                          empty_frame;

  modport source(output valid, output out_byte, output last, output frame_length,
                 output empty_frame, input ready);
  modport sink(input valid, input out_byte, input last, input frame_length,
               input empty_frame, output ready);
endinterface
`default_nettype wire

FILE: rtl/dle_stx_frame_receiver_unit.sv
`default_nettype none
// DLE/STX frame receiver.
// rx_in carries received serial bytes (valid/ready, one byte per request).
// rx_out carries unstuffed payload bytes; last marks the final byte of a
// frame and then frame_length holds its byte count. An empty frame gives a
// single request with last and empty_frame set.
// The APB port holds rx_enable (0x0) and max_frame_length (0x4); writes take
// effect at the access cycle and clearing rx_enable drops any partial frame.
// A byte accepted on rx_in is held in the input register and parsed from
// there; its results are written to the result queue, which drives rx_out.
// A payload byte appears only once the following byte of the frame has been
// parsed, but a byte that meets the length limit appears when it is parsed.
// Throughput: one byte per cycle while the queue has room. A byte ending a
// frame on the length limit can yield two results; the four entry queue
// absorbs them, and rx_in.ready drops only when under two entries are free.
// Reset clears the parser to the SYN hunt, empties the queue and restores
// rx_enable = 1, max_frame_length = 256. When rx_out stalls, results wait
// in the queue and rx_in backs up once fewer than two entries are free.
module dle_stx_frame_receiver_unit #(
  parameter int MAX_FRAME = dsfr_pkg::MAX_FRAME_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  dsfr_byte_if.sink                    rx_in,
  dsfr_result_if.source                rx_out,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [dsfr_pkg::ADDR_W-1:0]   paddr,
  input  wire [dsfr_pkg::DATA_W-1:0]   pwdata,
  output logic [dsfr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  dsfr_pkg::cfg_t     cfg;
  logic               room;
  logic [1:0]         res_cnt;
  dsfr_pkg::result_t  res_a;
  dsfr_pkg::result_t  res_b;

  dsfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (rx_in.valid),
    .in_byte  (rx_in.rx_byte),
    .in_ready (rx_in.ready),
    .room     (room),
    .res_cnt  (res_cnt),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  dsfr_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (res_cnt),
    .push_a   (res_a),
    .push_b   (res_b),
    .room     (room),
    .out      (rx_out)
  );

endmodule
`default_nettype wire

FILE: rtl/dsfr_cfg.sv
`default_nettype none
module dsfr_cfg (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [dsfr_pkg::ADDR_W-1:0]   paddr,
  input  wire [dsfr_pkg::DATA_W-1:0]   pwdata,
  output logic [dsfr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dsfr_pkg::cfg_t               cfg
);

  logic                        rx_enable;
  logic [dsfr_pkg::LEN_W-1:0]  max_frame_length;
  logic                        wr;
  logic                        idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b1;
      max_frame_length <= dsfr_pkg::MAX_LEN_RESET;
    end else if (wr) begin
      unique case (idx)
        dsfr_pkg::REG_RX_ENABLE: rx_enable <= pwdata[0];
        dsfr_pkg::REG_MAX_LEN:   max_frame_length <= pwdata[dsfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      dsfr_pkg::REG_RX_ENABLE: prdata[0] = rx_enable;
      dsfr_pkg::REG_MAX_LEN:   prdata[dsfr_pkg::LEN_W-1:0] = max_frame_length;
      default: ;
    endcase
  end

  assign cfg.rx_enable = rx_enable;
  assign cfg.max_frame_length = max_frame_length;
  assign cfg.drop = wr && (idx == dsfr_pkg::REG_RX_ENABLE) && !pwdata[0];

endmodule
`default_nettype wire

FILE: rtl/dsfr_parser.sv
`default_nettype none
module dsfr_parser #(
  parameter int MAX_FRAME = dsfr_pkg::MAX_FRAME_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire dsfr_pkg::cfg_t          cfg,
  input  wire                          in_valid,
  input  wire [dsfr_pkg::BYTE_W-1:0]   in_byte,
  output logic                         in_ready,
  input  wire                          room,
  output logic [1:0]                   res_cnt,
  output dsfr_pkg::result_t            res_a,
  output dsfr_pkg::result_t            res_b
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int LIM_W = (CNT_W > dsfr_pkg::LEN_W) ? CNT_W : dsfr_pkg::LEN_W;

  dsfr_pkg::phase_t             phase, phase_next;
  logic [CNT_W-1:0]             byte_count, byte_count_next;
  logic [dsfr_pkg::BYTE_W-1:0]  held_byte, held_byte_next;
  logic                         held_valid, held_valid_next;

  logic                         in_valid_q;
  logic [dsfr_pkg::BYTE_W-1:0]  in_byte_q;
  logic                         take;
  logic                         act;
  logic                         is_dle;
  logic [LIM_W-1:0]             mfl_ext;
  logic [LIM_W-1:0]             limit;
  logic [LIM_W-1:0]             cnt_ext;
  logic [LIM_W-1:0]             cnt_inc;
  logic                         hit;
  logic                         payload;
  logic                         ending;

  // input register
  assign take = in_valid_q && room;
  assign in_ready = !in_valid_q || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_q <= in_byte;
    end
  end

  // length limit, clamped to 1..MAX_FRAME
  assign mfl_ext = LIM_W'(cfg.max_frame_length);
  always_comb begin
    if (mfl_ext == '0) begin
      limit = LIM_W'(1);
    end else if (mfl_ext > LIM_W'(MAX_FRAME)) begin
      limit = LIM_W'(MAX_FRAME);
    end else begin
      limit = mfl_ext;
    end
  end

  assign cnt_ext = LIM_W'(byte_count);
  assign cnt_inc = cnt_ext + LIM_W'(1);
  assign hit = cnt_inc >= limit;
  assign is_dle = in_byte_q == dsfr_pkg::DLE_CHAR;
  assign act = take && cfg.rx_enable && !cfg.drop;
  assign payload = act && (((phase == dsfr_pkg::PH_DATA) && !is_dle) ||
                           ((phase == dsfr_pkg::PH_ESC) && is_dle));
  assign ending = act && (phase == dsfr_pkg::PH_ESC) && !is_dle;

  // next state
  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    held_byte_next = held_byte;
    held_valid_next = held_valid;
    if (cfg.drop || (take && !cfg.rx_enable)) begin
      phase_next = dsfr_pkg::PH_HUNT;
      byte_count_next = '0;
      held_valid_next = 1'b0;
    end else if (take) begin
      unique case (phase)
        dsfr_pkg::PH_HUNT: begin
          if (in_byte_q == dsfr_pkg::SYN_CHAR) begin
            phase_next = dsfr_pkg::PH_SYNS;
          end
        end
        dsfr_pkg::PH_SYNS: begin
          if (in_byte_q != dsfr_pkg::SYN_CHAR) begin
            phase_next = is_dle ? dsfr_pkg::PH_STX : dsfr_pkg::PH_HUNT;
          end
        end
        dsfr_pkg::PH_STX: begin
          phase_next = (in_byte_q == dsfr_pkg::STX_CHAR) ? dsfr_pkg::PH_DATA
                                                         : dsfr_pkg::PH_HUNT;
          byte_count_next = '0;
          held_valid_next = 1'b0;
        end
        dsfr_pkg::PH_DATA, dsfr_pkg::PH_ESC: begin
          if (payload) begin
            if (hit) begin
              phase_next = dsfr_pkg::PH_HUNT;
              byte_count_next = '0;
              held_valid_next = 1'b0;
            end else begin
              phase_next = dsfr_pkg::PH_DATA;
              byte_count_next = CNT_W'(cnt_inc);
              held_byte_next = in_byte_q;
              held_valid_next = 1'b1;
            end
          end else if (ending) begin
            phase_next = dsfr_pkg::PH_HUNT;
            byte_count_next = '0;
            held_valid_next = 1'b0;
          end else begin
            phase_next = dsfr_pkg::PH_ESC;
          end
        end
        default: begin
          phase_next = dsfr_pkg::PH_HUNT;
          byte_count_next = '0;
          held_valid_next = 1'b0;
        end
      endcase
    end
  end

  // results
  always_comb begin
    res_cnt = 2'd0;
    res_a = '0;
    res_b = '0;
    if (payload) begin
      if (held_valid) begin
        res_a.out_byte = held_byte;
        if (hit) begin
          res_b.out_byte = in_byte_q;
          res_b.last = 1'b1;
          res_b.frame_length = cnt_inc[dsfr_pkg::LEN_W-1:0];
          res_cnt = 2'd2;
        end else begin
          res_cnt = 2'd1;
        end
      end else if (hit) begin
        res_a.out_byte = in_byte_q;
        res_a.last = 1'b1;
        res_a.frame_length = cnt_inc[dsfr_pkg::LEN_W-1:0];
        res_cnt = 2'd1;
      end
    end else if (ending) begin
      res_cnt = 2'd1;
      res_a.last = 1'b1;
      if (held_valid) begin
        res_a.out_byte = held_byte;
        res_a.frame_length = cnt_ext[dsfr_pkg::LEN_W-1:0];
      end else begin
        res_a.empty_frame = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dsfr_pkg::PH_HUNT;
      byte_count <= '0;
      held_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
  end

  a_held_only_in_frame: assert property (@(posedge clk) disable iff (rst)
    !((phase == dsfr_pkg::PH_DATA) || (phase == dsfr_pkg::PH_ESC)) |-> !held_valid)
    else $error("held byte valid outside a frame");

  a_results_need_room: assert property (@(posedge clk) disable iff (rst)
    (res_cnt != 2'd0) |-> (take && room))
    else $error("results produced without output room");

  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.drop |=> ((phase == dsfr_pkg::PH_HUNT) && !held_valid && (byte_count == '0)))
    else $error("disable did not drop the frame");

endmodule
`default_nettype wire

FILE: rtl/dsfr_out_fifo.sv
`default_nettype none
module dsfr_out_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [1:0]            push_cnt,
  input  wire dsfr_pkg::result_t push_a,
  input  wire dsfr_pkg::result_t push_b,
  output logic                 room,
  dsfr_result_if.source        out
);

  localparam int DEPTH = dsfr_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsfr_pkg::result_t   mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                pop;
  dsfr_pkg::result_t   head;

  assign pop = out.valid && out.ready;
  assign room = count <= CNT_W'(DEPTH - 2);

  assign wr_ptr_next = wr_ptr + PTR_W'(push_cnt);
  assign rd_ptr_next = rd_ptr + PTR_W'(pop);
  assign count_next = count + CNT_W'(push_cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

  assign head = mem[rd_ptr];
  assign out.valid = count != '0;
  assign out.out_byte = head.out_byte;
  assign out.last = head.last;
  assign out.frame_length = head.frame_length;
  assign out.empty_frame = head.empty_frame;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_cnt != 2'd0) |-> ((CNT_W + 1)'(count) + (CNT_W + 1)'(push_cnt)
                            <= (CNT_W + 1)'(DEPTH)))
    else $error("result queue overflow");

endmodule
`default_nettype wire

FILE: dv/dle_stx_frame_receiver_unit_test.sv
`timescale 1ns / 1ps
module dle_stx_frame_receiver_unit_test;

  localparam int CAP_MAX = dsfr_pkg::MAX_FRAME_DEFAULT;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dsfr_byte_if rx_in_if();
  dsfr_result_if rx_out_if();

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [dsfr_pkg::ADDR_W-1:0] paddr;
  logic [dsfr_pkg::DATA_W-1:0] pwdata;
  logic [dsfr_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  dle_stx_frame_receiver_unit dut (
    .clk(clk),
    .rst(rst),
    .rx_in(rx_in_if),
    .rx_out(rx_out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // line bytes waiting to be sent and deframed results still owed
  logic [dsfr_pkg::BYTE_W-1:0] line_bytes[$];
  dsfr_pkg::result_t           owed_results[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int configs_used = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int src_idle = 0;
  int sink_stall = 0;

  // deframer shadow state
  dsfr_pkg::phase_t            sh_phase;
  int                          sh_count;
  logic [dsfr_pkg::BYTE_W-1:0] sh_held;
  bit                          sh_held_ok;
  bit                          sh_enable;
  logic [dsfr_pkg::LEN_W-1:0]  sh_max_len;

  function automatic int frame_cap();
    int c;
    c = int'(sh_max_len);
    if (c < 1) c = 1;
    if (c > CAP_MAX) c = CAP_MAX;
    return c;
  endfunction

  function automatic void abandon_frame();
    sh_phase = dsfr_pkg::PH_HUNT;
    sh_count = 0;
    sh_held_ok = 1'b0;
    sh_held = '0;
  endfunction

  function automatic void owe(logic [dsfr_pkg::BYTE_W-1:0] b, logic l, int len, logic e);
    dsfr_pkg::result_t r;
    r.out_byte = b;
    r.last = l;
    r.frame_length = dsfr_pkg::LEN_W'(len);
    r.empty_frame = e;
    owed_results.push_back(r);
  endfunction

  function automatic void take_payload(logic [dsfr_pkg::BYTE_W-1:0] b);
    sh_count++;
    if (sh_held_ok) owe(sh_held, 1'b0, 0, 1'b0);
    if (sh_count >= frame_cap()) begin
      owe(b, 1'b1, sh_count, 1'b0);
      abandon_frame();
    end else begin
      sh_held = b;
      sh_held_ok = 1'b1;
      sh_phase = dsfr_pkg::PH_DATA;
    end
  endfunction

  function automatic void deframe_byte(logic [dsfr_pkg::BYTE_W-1:0] c);
    if (!sh_enable) begin
      abandon_frame();
      return;
    end
    case (sh_phase)
      dsfr_pkg::PH_HUNT: begin
        if (c == dsfr_pkg::SYN_CHAR) sh_phase = dsfr_pkg::PH_SYNS;
      end
      dsfr_pkg::PH_SYNS: begin
        if (c != dsfr_pkg::SYN_CHAR)
          sh_phase = (c == dsfr_pkg::DLE_CHAR) ? dsfr_pkg::PH_STX : dsfr_pkg::PH_HUNT;
      end
      dsfr_pkg::PH_STX: begin
        if (c == dsfr_pkg::STX_CHAR) begin
          sh_phase = dsfr_pkg::PH_DATA;
          sh_count = 0;
          sh_held_ok = 1'b0;
        end else begin
          abandon_frame();
        end
      end
      dsfr_pkg::PH_DATA: begin
        if (c == dsfr_pkg::DLE_CHAR) sh_phase = dsfr_pkg::PH_ESC;
        else take_payload(c);
      end
      dsfr_pkg::PH_ESC: begin
        if (c == dsfr_pkg::DLE_CHAR) begin
          take_payload(c);
        end else begin
          if (sh_held_ok) owe(sh_held, 1'b1, sh_count, 1'b0);
          else owe('0, 1'b1, 0, 1'b1);
          abandon_frame();
        end
      end
      default: abandon_frame();
    endcase
  endfunction

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_in_if.valid <= 1'b0;
    end else begin
      if (rx_in_if.valid && rx_in_if.ready) begin
        deframe_byte(rx_in_if.rx_byte);
        bytes_taken++;
      end
      if (!(rx_in_if.valid && !rx_in_if.ready)) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= src_idle) begin
          rx_in_if.valid <= 1'b1;
          rx_in_if.rx_byte <= line_bytes.pop_front();
        end else begin
          rx_in_if.valid <= 1'b0;
          rx_in_if.rx_byte <= dsfr_pkg::BYTE_W'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    dsfr_pkg::result_t want;
    if (rst) begin
      rx_out_if.ready <= 1'b0;
    end else begin
      if (rx_out_if.valid && rx_out_if.ready) begin
        results_seen++;
        if (rx_out_if.last) frames_seen++;
        if (owed_results.size() == 0) begin
          log_error($sformatf("unexpected request: byte %02h last %0b len %0d empty %0b",
                              rx_out_if.out_byte, rx_out_if.last, rx_out_if.frame_length,
                              rx_out_if.empty_frame));
        end else begin
          want = owed_results.pop_front();
          if ((!want.empty_frame && rx_out_if.out_byte !== want.out_byte) ||
              rx_out_if.last !== want.last ||
              rx_out_if.frame_length !== want.frame_length ||
              rx_out_if.empty_frame !== want.empty_frame)
            log_error($sformatf({"mismatch: exp byte %02h last %0b len %0d empty %0b,",
                                 " got byte %02h last %0b len %0d empty %0b"},
                                want.out_byte, want.last, want.frame_length,
                                want.empty_frame, rx_out_if.out_byte, rx_out_if.last,
                                rx_out_if.frame_length, rx_out_if.empty_frame));
        end
      end
      rx_out_if.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("[dle_stx_frame_receiver_unit] ERROR");
    $finish;
  end

  task automatic put(input logic [dsfr_pkg::BYTE_W-1:0] b);
    line_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic put_stuffed(input logic [dsfr_pkg::BYTE_W-1:0] b);
    put(b);
    if (b == dsfr_pkg::DLE_CHAR) put(dsfr_pkg::DLE_CHAR);
  endtask

  function automatic logic [dsfr_pkg::BYTE_W-1:0] payload_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return dsfr_pkg::DLE_CHAR;
    if (r < 25) return dsfr_pkg::SYN_CHAR;
    if (r < 28) return dsfr_pkg::STX_CHAR;
    if (r < 31) return dsfr_pkg::ETX_CHAR;
    return dsfr_pkg::BYTE_W'($urandom);
  endfunction

  task automatic put_frame(input int len, input bit trailer);
    logic [dsfr_pkg::BYTE_W-1:0] t;
    repeat ($urandom_range(1, 3)) put(dsfr_pkg::SYN_CHAR);
    put(dsfr_pkg::DLE_CHAR);
    put(dsfr_pkg::STX_CHAR);
    repeat (len) put_stuffed(payload_byte());
    if (trailer) begin
      put(dsfr_pkg::DLE_CHAR);
      if ($urandom_range(99) < 85) begin
        put(dsfr_pkg::ETX_CHAR);
      end else begin
        do t = dsfr_pkg::BYTE_W'($urandom); while (t == dsfr_pkg::DLE_CHAR);
        put(t);
      end
    end
  endtask

  task automatic put_noise();
    logic [dsfr_pkg::BYTE_W-1:0] t;
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 6)) put(dsfr_pkg::BYTE_W'($urandom));
      1: begin
        put(dsfr_pkg::SYN_CHAR);
        do t = dsfr_pkg::BYTE_W'($urandom);
        while (t == dsfr_pkg::SYN_CHAR || t == dsfr_pkg::DLE_CHAR);
        put(t);
      end
      2: begin
        put(dsfr_pkg::SYN_CHAR);
        put(dsfr_pkg::DLE_CHAR);
        do t = dsfr_pkg::BYTE_W'($urandom); while (t == dsfr_pkg::STX_CHAR);
        put(t);
      end
      default: put_frame($urandom_range(0, 4), 1'b0);
    endcase
  endtask

  task automatic wait_quiet();
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == dsfr_pkg::REG_RX_ENABLE) begin
      sh_enable = value[0];
      if (!sh_enable) abandon_frame();
    end else begin
      sh_max_len = value[dsfr_pkg::LEN_W-1:0];
    end
    configs_used++;
  endtask

  task automatic run_traffic(input int n, input bit long_frame, input bit pause_midway);
    int start;
    int r;
    bit paused;
    paused = 1'b0;
    if (long_frame) put_frame(260, 1'b1);
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      if (pause_midway && !paused && bytes_queued - start >= n / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 75) begin
        if ($urandom_range(9) == 0) put_frame(0, 1'b1);
        else if ($urandom_range(9) == 0) put_frame($urandom_range(11, 40), 1'b1);
        else put_frame($urandom_range(1, 10), 1'b1);
      end else begin
        put_noise();
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst = 1'b1;
    rx_in_if.valid = 1'b0;
    rx_in_if.rx_byte = '0;
    rx_out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sh_enable = 1'b1;
    sh_max_len = dsfr_pkg::MAX_LEN_RESET;
    abandon_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // extremes, stuffed DLE, repeated SYN
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR);
    put(dsfr_pkg::STX_CHAR);
    put(8'h00); put(8'hFF); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::DLE_CHAR); put(8'h55);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::ETX_CHAR);
    // empty frame
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::ETX_CHAR);
    // mismatch after SYN, then after DLE with a SYN that must not count
    put(dsfr_pkg::SYN_CHAR); put(8'h41);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::SYN_CHAR);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR); put(8'h33);
    // trailer other than ETX
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR); put(8'hAA);
    put(dsfr_pkg::DLE_CHAR); put(8'h7E);
    wait_quiet();

    // length limit
    write_reg(dsfr_pkg::REG_MAX_LEN, 2);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR);
    put(8'h01); put(8'h02); put(8'h03);
    wait_quiet();

    // limit lowered mid-frame
    write_reg(dsfr_pkg::REG_MAX_LEN, 256);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR);
    put(8'h01); put(8'h02); put(8'h03); put(8'h04);
    wait_quiet();
    write_reg(dsfr_pkg::REG_MAX_LEN, 2);
    put(8'h05);
    wait_quiet();

    // disable drops a partial frame
    write_reg(dsfr_pkg::REG_MAX_LEN, 256);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR);
    put(8'h01); put(8'h02);
    wait_quiet();
    write_reg(dsfr_pkg::REG_RX_ENABLE, 0);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR); put(8'h09);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::ETX_CHAR);
    wait_quiet();
    write_reg(dsfr_pkg::REG_RX_ENABLE, 1);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::ETX_CHAR);
    put(dsfr_pkg::SYN_CHAR); put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::STX_CHAR); put(8'h5A);
    put(dsfr_pkg::DLE_CHAR); put(dsfr_pkg::ETX_CHAR);
    wait_quiet();

    src_idle = 0; sink_stall = 0;
    run_traffic(30, 1'b0, 1'b0);

    write_reg(dsfr_pkg::REG_MAX_LEN, 3);
    src_idle = 61; sink_stall = 0;
    run_traffic(30, 1'b0, 1'b0);

    write_reg(dsfr_pkg::REG_MAX_LEN, 0);
    src_idle = 0; sink_stall = 61;
    run_traffic(30, 1'b0, 1'b0);

    write_reg(dsfr_pkg::REG_RX_ENABLE, 0);
    src_idle = 17; sink_stall = 17;
    run_traffic(20, 1'b0, 1'b0);
    write_reg(dsfr_pkg::REG_RX_ENABLE, 1);

    write_reg(dsfr_pkg::REG_MAX_LEN, 511);
    run_traffic(40, 1'b1, 1'b1);

    write_reg(dsfr_pkg::REG_MAX_LEN, $urandom_range(4, 24));
    src_idle = 61; sink_stall = 61;
    run_traffic(30, 1'b0, 1'b0);

    $display("checked %0d results in %0d frames from %0d line bytes", results_seen,
             frames_seen, bytes_taken);
    $display("%0d register writes, limits 0..511, reception off and on, %0d errors",
             configs_used, errors);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("[dle_stx_frame_receiver_unit] OK");
    end else begin
      $display("[dle_stx_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dsfr_pkg.sv
rtl/dsfr_if.sv
rtl/dsfr_cfg.sv
rtl/dsfr_parser.sv
rtl/dsfr_out_fifo.sv
rtl/dle_stx_frame_receiver_unit.sv
dv/dle_stx_frame_receiver_unit_test.sv
